/* rtl/core/u8r_pkg.sv */
// shared types, constants and decode functions for the utf-8 repair core
package u8r_pkg;

  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD2_MIN    = 8'hC2;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT   = 8'hF5;
  localparam logic [7:0] LEAD_SURR    = 8'hED;
  localparam logic [7:0] LEAD_MAX     = 8'hF4;
  localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
  localparam logic [7:0] F0_CONT_MIN  = 8'h90;
  localparam logic [1:0] CONT_TAG     = 2'b10;
  localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
  localparam logic [15:0] CP_2B_LIMIT = 16'h0800;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_EMIT,
    S_FINISH
  } u8r_state_t;

  typedef enum logic [1:0] {
    RUN_INVALID,
    RUN_INCOMPLETE,
    RUN_COMPLETE
  } run_st_t;

  typedef struct packed {
    run_st_t    st;
    logic [2:0] need;
  } run_info_t;

  typedef struct packed {
    logic load;
    logic start_copy;
    logic start_fb;
    logic emit;
    logic flush;
  } u8r_cmd_t;

  typedef struct packed {
    run_st_t run_st;
    logic    buf_empty;
    logic    last;
    logic    emit_ok;
    logic    run_end;
    logic    hold_vld;
    logic    out_free;
  } u8r_sts_t;

  // cp1252 code point for a byte; unassigned c1 bytes keep their latin-1 value
  function automatic logic [15:0] cp1252_cp(input logic [7:0] b);
    logic [15:0] cp;
    case (b)
      8'h80:   cp = 16'h20AC;
      8'h82:   cp = 16'h201A;
      8'h83:   cp = 16'h0192;
      8'h84:   cp = 16'h201E;
      8'h85:   cp = 16'h2026;
      8'h86:   cp = 16'h2020;
      8'h87:   cp = 16'h2021;
      8'h88:   cp = 16'h02C6;
      8'h89:   cp = 16'h2030;
      8'h8A:   cp = 16'h0160;
      8'h8B:   cp = 16'h2039;
      8'h8C:   cp = 16'h0152;
      8'h8E:   cp = 16'h017D;
      8'h91:   cp = 16'h2018;
      8'h92:   cp = 16'h2019;
      8'h93:   cp = 16'h201C;
      8'h94:   cp = 16'h201D;
      8'h95:   cp = 16'h2022;
      8'h96:   cp = 16'h2013;
      8'h97:   cp = 16'h2014;
      8'h98:   cp = 16'h02DC;
      8'h99:   cp = 16'h2122;
      8'h9A:   cp = 16'h0161;
      8'h9B:   cp = 16'h203A;
      8'h9C:   cp = 16'h0153;
      8'h9E:   cp = 16'h017E;
      8'h9F:   cp = 16'h0178;
      default: cp = {8'h00, b};
    endcase
    return cp;
  endfunction

  // strict utf-8 check of the run at the buffer head, have = bytes present
  function automatic run_info_t classify_run(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] have);
    logic [2:0] len;
    logic       bad;
    run_info_t  r;
    len = 3'd1;
    bad = 1'b0;
    if (b0 < ASCII_LIMIT) begin
      len = 3'd1;
    end else if (b0 < LEAD2_MIN) begin
      bad = 1'b1;
    end else if (b0 < LEAD3_MIN) begin
      len = 3'd2;
    end else if (b0 < LEAD4_MIN) begin
      len = 3'd3;
    end else if (b0 < LEAD_LIMIT) begin
      len = 3'd4;
    end else begin
      bad = 1'b1;
    end
    if (have >= 3'd2 && len >= 3'd2 && b1[7:6] != CONT_TAG) bad = 1'b1;
    if (have >= 3'd3 && len >= 3'd3 && b2[7:6] != CONT_TAG) bad = 1'b1;
    if (have >= 3'd4 && len >= 3'd4 && b3[7:6] != CONT_TAG) bad = 1'b1;
    if (have >= 3'd2) begin
      // overlong, surrogate and above-range forms
      if (b0 == LEAD3_MIN && b1 < E0_CONT_MIN) bad = 1'b1;
      if (b0 == LEAD_SURR && b1 >= E0_CONT_MIN) bad = 1'b1;
      if (b0 == LEAD4_MIN && b1 < F0_CONT_MIN) bad = 1'b1;
      if (b0 == LEAD_MAX && b1 >= F0_CONT_MIN) bad = 1'b1;
    end
    r.need = len;
    if (bad) begin
      r.st = RUN_INVALID;
    end else if (have < len) begin
      r.st = RUN_INCOMPLETE;
    end else begin
      r.st = RUN_COMPLETE;
    end
    return r;
  endfunction

endpackage

/* rtl/core/u8r_ctrl.sv */
// sequencer: accepts a word, resolves runs at the buffer head, closes each item
module u8r_ctrl
  import u8r_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  u8r_sts_t sts,
  output u8r_cmd_t cmd
);

  u8r_state_t state_r;
  u8r_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.buf_empty) begin
          state_nxt = S_FINISH;
        end else begin
          case (sts.run_st)
            RUN_COMPLETE: begin
              cmd.start_copy = 1'b1;
              state_nxt      = S_EMIT;
            end
            RUN_INCOMPLETE: begin
              // hold the run unless the text ends here
              if (sts.last) begin
                cmd.start_fb = 1'b1;
                state_nxt    = S_EMIT;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            default: begin
              cmd.start_fb = 1'b1;
              state_nxt    = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (sts.emit_ok) begin
          cmd.emit = 1'b1;
          if (sts.run_end) state_nxt = S_DECIDE;
        end
      end
      S_FINISH: begin
        if (!sts.hold_vld) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/u8r_dp.sv */
// datapath: pending byte buffer, run check, cp1252 encoder, hold and output registers
module u8r_dp
  import u8r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  u8r_cmd_t   cmd,
  output u8r_sts_t   sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end,
  output logic       out_transcoded
);

  logic [7:0] buf_r [4];
  logic [7:0] buf_nxt [4];
  logic [2:0] n_r, n_nxt;
  logic       last_r, last_nxt;
  logic       mode_fb_r, mode_fb_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       hold_tr_r, hold_tr_nxt;
  logic       hold_vld_r, hold_vld_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_rl_r, out_rl_nxt;
  logic       out_te_r, out_te_nxt;
  logic       out_tr_r, out_tr_nxt;

  run_info_t   run;
  logic [15:0] cp;
  logic [2:0]  enc_len;
  logic [7:0]  enc0, enc1, enc2;
  logic [7:0]  enc_sel;
  logic        out_free;
  logic        emit_ok;
  logic        run_end;

  assign run      = classify_run(buf_r[0], buf_r[1], buf_r[2], buf_r[3], n_r);
  assign out_free = !out_valid_r || !out_stall;
  assign emit_ok  = !hold_vld_r || out_free;
  assign run_end  = (rem_r == 3'd1);

  // fallback encoding of the head byte
  always_comb begin
    cp   = cp1252_cp(buf_r[0]);
    enc0 = cp[7:0];
    enc1 = '0;
    enc2 = '0;
    if (cp < CP_1B_LIMIT) begin
      enc_len = 3'd1;
    end else if (cp < CP_2B_LIMIT) begin
      enc_len = 3'd2;
      enc0    = {3'b110, cp[10:6]};
      enc1    = {CONT_TAG, cp[5:0]};
    end else begin
      enc_len = 3'd3;
      enc0    = {4'b1110, cp[15:12]};
      enc1    = {CONT_TAG, cp[11:6]};
      enc2    = {CONT_TAG, cp[5:0]};
    end
    case (idx_r)
      2'd0:    enc_sel = enc0;
      2'd1:    enc_sel = enc1;
      default: enc_sel = enc2;
    endcase
  end

  always_comb begin
    sts.run_st    = run.st;
    sts.buf_empty = (n_r == 3'd0);
    sts.last      = last_r;
    sts.emit_ok   = emit_ok;
    sts.run_end   = run_end;
    sts.hold_vld  = hold_vld_r;
    sts.out_free  = out_free;
  end

  always_comb begin
    buf_nxt       = buf_r;
    n_nxt         = n_r;
    last_nxt      = last_r;
    mode_fb_nxt   = mode_fb_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    hold_byte_nxt = hold_byte_r;
    hold_tr_nxt   = hold_tr_r;
    hold_vld_nxt  = hold_vld_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_rl_nxt    = out_rl_r;
    out_te_nxt    = out_te_r;
    out_tr_nxt    = out_tr_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cmd.load) begin
      buf_nxt[n_r[1:0]] = in_byte;
      n_nxt             = n_r + 3'd1;
      last_nxt          = in_last;
    end
    if (cmd.start_copy) begin
      mode_fb_nxt = 1'b0;
      rem_nxt     = run.need;
    end
    if (cmd.start_fb) begin
      mode_fb_nxt = 1'b1;
      rem_nxt     = enc_len;
      idx_nxt     = 2'd0;
    end
    if (cmd.emit) begin
      // a newer word follows, so the held one is not the item's last
      if (hold_vld_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hold_byte_r;
        out_tr_nxt    = hold_tr_r;
        out_rl_nxt    = 1'b0;
        out_te_nxt    = 1'b0;
      end
      hold_vld_nxt = 1'b1;
      rem_nxt      = rem_r - 3'd1;
      if (mode_fb_r) begin
        hold_byte_nxt = enc_sel;
        hold_tr_nxt   = 1'b1;
        idx_nxt       = idx_r + 2'd1;
      end else begin
        hold_byte_nxt = buf_r[0];
        hold_tr_nxt   = 1'b0;
      end
      if (!mode_fb_r || run_end) begin
        buf_nxt[0] = buf_r[1];
        buf_nxt[1] = buf_r[2];
        buf_nxt[2] = buf_r[3];
        n_nxt      = n_r - 3'd1;
      end
    end
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hold_byte_r;
      out_tr_nxt    = hold_tr_r;
      out_rl_nxt    = 1'b1;
      out_te_nxt    = last_r;
      hold_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    last_r      <= last_nxt;
    mode_fb_r   <= mode_fb_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_tr_r   <= hold_tr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_rl_r    <= out_rl_nxt;
    out_te_r    <= out_te_nxt;
    out_tr_r    <= out_tr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_rl_r;
  assign out_text_end   = out_te_r;
  assign out_transcoded = out_tr_r;

  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 3'd4)
    else $error("pending buffer overfilled");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> n_r <= 3'd3)
    else $error("word loaded into a full buffer");

  a_end_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && last_r) |-> n_r == 3'd0)
    else $error("text ended with bytes still pending");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.emit && hold_vld_r) || cmd.flush) |-> out_free)
    else $error("output register overwritten while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_te_r) |-> out_rl_r)
    else $error("text end without run end");

endmodule

/* rtl/core/utf8_repair_cp1252_fallback_core.sv */
// top level of the utf-8 repair core with cp1252/latin-1 fallback
//
//   channel  direction  handshake              fields
//   in_      input      in_valid / in_stall    in_byte[7:0], in_last
//   out_     output     out_valid / out_stall  out_byte[7:0], out_run_last,
//                                              out_text_end, out_transcoded
//
// an item is handled in order: accept the word, then one decision per run resolved at the
// buffer head plus a closing one, one emit per output word, and a last step to close the item
// a single shared head-of-buffer decode serves every run; the emit path moves one word per
// cycle unless out_stall holds the output register and a word already waits in the hold stage
// reset is synchronous, active low; it empties the pending buffer and output registers
// out_stall holds words in the output register; one more word waits in a hold stage
module utf8_repair_cp1252_fallback_core
  import u8r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end,
  output logic       out_transcoded
);

  u8r_cmd_t cmd;
  u8r_sts_t sts;

  u8r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8r_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_text_end   (out_text_end),
    .out_transcoded (out_transcoded)
  );

endmodule

/* tb/tb.sv */
// self-checking testbench for the utf-8 repair core with cp1252/latin-1 fallback
module tb;
  import u8r_pkg::*;

  localparam int HOLD_CYCLES = 160;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_BYTES = 385;
  localparam int MAX_REPORTS = 100;

  // cp1252 code points for 0x80..0x9f, zero where the byte is unassigned
  localparam logic [15:0] C1_POINTS [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
    logic       transcoded;
  } utf8_word_t;

  class repair_tracker;
    utf8_word_t due_words[$];
    logic [7:0] held[3];
    int         held_cnt = 0;
    logic [7:0] work[4];
    int         errors = 0;
    int         checked = 0;
    int         fallback_words = 0;

    function int pending();
      return due_words.size();
    endfunction

    function void add_word(logic [7:0] b, logic tr);
      utf8_word_t w;
      w.data = b;
      w.run_last = 1'b0;
      w.text_end = 1'b0;
      w.transcoded = tr;
      due_words.push_back(w);
    endfunction

    // strict decode of the run starting at work[pos], n bytes in the buffer
    function run_st_t scan_run(int pos, int n, output int len);
      logic [7:0] lead;
      logic [7:0] second;
      int have;
      int k;
      lead = work[pos];
      have = n - pos;
      len = 1;
      if (lead >= LEAD_LIMIT || (lead >= ASCII_LIMIT && lead < LEAD2_MIN)) return RUN_INVALID;
      if (lead >= LEAD4_MIN) len = 4;
      else if (lead >= LEAD3_MIN) len = 3;
      else if (lead >= LEAD2_MIN) len = 2;
      for (k = 1; k < len && k < have; k++) begin
        if (work[pos + k][7:6] != 2'b10) return RUN_INVALID;
      end
      if (have >= 2) begin
        second = work[pos + 1];
        // overlong, surrogate and beyond-range second bytes
        if (lead == LEAD3_MIN && second < E0_CONT_MIN) return RUN_INVALID;
        if (lead == LEAD_SURR && second >= E0_CONT_MIN) return RUN_INVALID;
        if (lead == LEAD4_MIN && second < F0_CONT_MIN) return RUN_INVALID;
        if (lead == LEAD_MAX && second >= F0_CONT_MIN) return RUN_INVALID;
      end
      if (have < len) return RUN_INCOMPLETE;
      return RUN_COMPLETE;
    endfunction

    function void add_fallback(logic [7:0] b);
      logic [15:0] cp;
      cp = {8'h00, b};
      if (b[7:5] == 3'b100 && C1_POINTS[b[4:0]] != 16'h0000) cp = C1_POINTS[b[4:0]];
      if (cp < 16'h0080) begin
        add_word(cp[7:0], 1'b1);
      end else if (cp < 16'h0800) begin
        add_word({3'b110, cp[10:6]}, 1'b1);
        add_word({2'b10, cp[5:0]}, 1'b1);
      end else begin
        add_word({4'b1110, cp[15:12]}, 1'b1);
        add_word({2'b10, cp[11:6]}, 1'b1);
        add_word({2'b10, cp[5:0]}, 1'b1);
      end
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      int n;
      int pos;
      int len;
      int first;
      int i;
      run_st_t st;
      first = due_words.size();
      n = held_cnt;
      for (i = 0; i < n; i++) work[i] = held[i];
      work[n] = b;
      n++;
      pos = 0;
      while (pos < n) begin
        st = scan_run(pos, n, len);
        if (st == RUN_COMPLETE) begin
          for (i = 0; i < len; i++) add_word(work[pos + i], 1'b0);
          pos += len;
        end else if (st == RUN_INCOMPLETE && !fin) begin
          break;
        end else begin
          add_fallback(work[pos]);
          pos++;
        end
      end
      if (fin) begin
        held_cnt = 0;
      end else begin
        held_cnt = n - pos;
        for (i = 0; i < held_cnt; i++) held[i] = work[pos + i];
      end
      if (due_words.size() > first) begin
        due_words[due_words.size() - 1].run_last = 1'b1;
        due_words[due_words.size() - 1].text_end = fin;
      end
    endfunction

    function void mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_word(logic [7:0] b, logic rl, logic te, logic tr);
      utf8_word_t w;
      checked++;
      if (due_words.size() == 0) begin
        mismatch("out_byte (no word due)", 8'h00, b);
        return;
      end
      w = due_words.pop_front();
      if (w.transcoded) fallback_words++;
      if (b !== w.data) mismatch("out_byte", w.data, b);
      if (rl !== w.run_last) mismatch("out_run_last", w.run_last, rl);
      if (te !== w.text_end) mismatch("out_text_end", w.text_end, te);
      if (tr !== w.transcoded) mismatch("out_transcoded", w.transcoded, tr);
    endfunction

    function void close();
      if (due_words.size() != 0) begin
        errors += due_words.size();
        $error("%0d expected words never arrived", due_words.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_end;
  logic       out_transcoded;

  repair_tracker tracker = new();
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            sent = 0;
  int            texts = 0;
  logic [7:0]    text_q[$];
  logic [7:0]    char_q[$];

  utf8_repair_cp1252_fallback_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end),
    .out_transcoded(out_transcoded)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words still due", tracker.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] pick(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // one well-formed character of random length and content
  function automatic void make_char();
    logic [7:0] lead;
    char_q.delete();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        char_q.push_back(pick(8'h00, 8'h7F));
      end
      3, 4: begin
        char_q.push_back(pick(8'hC2, 8'hDF));
        char_q.push_back(pick(8'h80, 8'hBF));
      end
      5, 6: begin
        lead = pick(8'hE0, 8'hEF);
        char_q.push_back(lead);
        if (lead == LEAD3_MIN) char_q.push_back(pick(8'hA0, 8'hBF));
        else if (lead == LEAD_SURR) char_q.push_back(pick(8'h80, 8'h9F));
        else char_q.push_back(pick(8'h80, 8'hBF));
        char_q.push_back(pick(8'h80, 8'hBF));
      end
      default: begin
        lead = pick(8'hF0, 8'hF4);
        char_q.push_back(lead);
        if (lead == LEAD4_MIN) char_q.push_back(pick(8'h90, 8'hBF));
        else if (lead == LEAD_MAX) char_q.push_back(pick(8'h80, 8'h8F));
        else char_q.push_back(pick(8'h80, 8'hBF));
        char_q.push_back(pick(8'h80, 8'hBF));
        char_q.push_back(pick(8'h80, 8'hBF));
      end
    endcase
  endfunction

  // mostly valid characters, some cut short or corrupted, some raw noise
  function automatic void make_text();
    int mode;
    int cut;
    text_q.delete();
    repeat ($urandom_range(1, 8)) begin
      mode = $urandom_range(0, 9);
      if (mode < 9) make_char();
      if (mode == 7 || mode == 8) begin
        if (char_q.size() > 1) begin
          cut = $urandom_range(1, char_q.size() - 1);
          if (mode == 7) begin
            while (char_q.size() > cut) char_q.pop_back();
          end else begin
            char_q[cut] = pick(8'h00, 8'hFF);
          end
        end
      end
      if (mode == 9) begin
        text_q.push_back(pick(8'h00, 8'hFF));
      end else begin
        foreach (char_q[i]) text_q.push_back(char_q[i]);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b, fin);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    texts++;
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // ascii extremes, valid 2/3/4-byte forms at their bounds, then bad leads,
    // overlong, surrogate and out-of-range forms, and a run cut by end of text
    text_q = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
               8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'h81, 8'hC0, 8'hED, 8'hA0,
               8'hF0, 8'h8F, 8'hF4, 8'h90, 8'hFF, 8'hE2, 8'h82};
    send_text();
    while (sent < RANDOM_BYTES + 26) begin
      calm = ($urandom_range(0, 4) == 0);
      if (texts == 8) hold_req = 1'b1;
      if (texts == 30) drain_output();
      make_text();
      send_text();
    end
    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close();
    $display("sent %0d bytes in %0d texts; checked %0d words, %0d of them from fallback",
             sent, texts, tracker.checked, tracker.fallback_words);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: random stall after each word, one long hold-off on request
  initial begin : receiver
    int gap;
    gap = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.check_word(out_byte, out_run_last, out_text_end, out_transcoded);
        gap = calm ? 0 : $urandom_range(0, 6);
      end else if (gap > 0) begin
        gap--;
      end
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        gap = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (gap > 0);
      end
    end
  end

endmodule

/* sim.f */
rtl/core/u8r_pkg.sv
rtl/core/u8r_ctrl.sv
rtl/core/u8r_dp.sv
rtl/core/utf8_repair_cp1252_fallback_core.sv
tb/tb.sv
